### rtl/core/mlq_pkg.sv
package mlq_pkg;

	localparam int DEF_PRIO_LEVELS = 8;
	localparam int DEF_QUEUE_DEPTH = 16;
	localparam int DEF_ID_BITS     = 8;

	// Widest process id the store may hold.
	localparam int MAX_ID_BITS = 16;

	// Fixed field widths of the request and result channels.
	localparam int PID_W   = 8;
	localparam int LEVEL_W = 3;
	localparam int SLOTS_W = 4;

	typedef enum logic {
		OP_ENQUEUE  = 1'b0,
		OP_DISPATCH = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Result fields known at acceptance; the id comes later from the store's read data.
	typedef struct packed {
		status_t              status;
		logic [LEVEL_W-1:0]   level;
		logic [SLOTS_W-1:0]   slots;
		logic                 use_rd;
	} res_t;

endpackage

### rtl/core/mlq_ram.sv
module mlq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule

### rtl/core/mlq_ctrl.sv
module mlq_ctrl import mlq_pkg::*; #(
	parameter int PRIO_LEVELS = DEF_PRIO_LEVELS,
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
	parameter int ID_BITS     = DEF_ID_BITS,
	localparam int ADDR_W     = $clog2(PRIO_LEVELS * QUEUE_DEPTH)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 acc,
	input  op_t                  opcode,
	input  logic [PID_W-1:0]     proc_id,
	input  logic [LEVEL_W-1:0]   level,
	output logic                 ram_en,
	output logic                 ram_we,
	output logic [ADDR_W-1:0]    ram_addr,
	output logic [ID_BITS-1:0]   ram_wdata,
	output res_t                 res
);

	localparam int LVL_W = $clog2(PRIO_LEVELS);
	localparam int BUD_W = $clog2(PRIO_LEVELS + 1);
	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [PTR_W-1:0] head_q  [PRIO_LEVELS];
	logic [CNT_W-1:0] count_q [PRIO_LEVELS];
	logic [LVL_W-1:0] serving_q;
	logic [BUD_W-1:0] budget_q;

	logic [PRIO_LEVELS-1:0] nonempty;
	logic                   any;
	logic [LVL_W-1:0]       first;
	logic [LVL_W-1:0]       lvl_enq;
	logic                   keep;
	logic [LVL_W-1:0]       cur;
	logic [LVL_W-1:0]       cur_next;
	logic [BUD_W-1:0]       bud_load;
	logic [BUD_W-1:0]       bud_new;
	logic [LVL_W-1:0]       idx;
	logic [PTR_W-1:0]       head_sel;
	logic [CNT_W-1:0]       cnt_sel;
	logic                   full;
	logic [PTR_W:0]         pos_sum;
	logic [PTR_W-1:0]       pos;
	logic [PTR_W-1:0]       head_inc;
	logic                   is_enq;
	logic [MAX_ID_BITS-1:0] pid_wide;

	always_comb begin
		for (int i = 0; i < PRIO_LEVELS; i++) begin
			nonempty[i] = (count_q[i] != '0);
		end
		any   = |nonempty;
		first = '0;
		for (int i = PRIO_LEVELS - 1; i >= 0; i--) begin
			if (nonempty[i]) begin
				first = LVL_W'(i);
			end
		end
	end

	always_comb begin
		is_enq = (opcode == OP_ENQUEUE);
		if (32'(level) >= PRIO_LEVELS) begin
			lvl_enq = LVL_W'(PRIO_LEVELS - 1);
		end else begin
			lvl_enq = LVL_W'(level);
		end

		// Every level above the lowest non-empty one is empty, so both the
		// fallback and the circular search land on the lowest non-empty level.
		keep     = !(any && first < serving_q) && budget_q != '0 && nonempty[serving_q];
		cur      = keep ? serving_q : first;
		bud_load = keep ? budget_q : BUD_W'(PRIO_LEVELS) - BUD_W'(first);
		bud_new  = bud_load - 1'b1;
		cur_next = (cur == LVL_W'(PRIO_LEVELS - 1)) ? '0 : cur + 1'b1;

		idx      = is_enq ? lvl_enq : cur;
		head_sel = head_q[idx];
		cnt_sel  = count_q[idx];
		full     = (cnt_sel == CNT_W'(QUEUE_DEPTH));

		pos_sum = (PTR_W+1)'(head_sel) + (PTR_W+1)'(cnt_sel);
		if (is_enq) begin
			if (pos_sum >= (PTR_W+1)'(QUEUE_DEPTH)) begin
				pos = PTR_W'(pos_sum - (PTR_W+1)'(QUEUE_DEPTH));
			end else begin
				pos = PTR_W'(pos_sum);
			end
		end else begin
			pos = head_sel;
		end
		head_inc = (head_sel == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_sel + 1'b1;

		pid_wide  = MAX_ID_BITS'(proc_id);
		ram_wdata = pid_wide[ID_BITS-1:0];
		ram_addr  = ADDR_W'(idx) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(pos);
		ram_we    = acc && is_enq;
		ram_en    = acc && (is_enq ? !full : any);
	end

	always_comb begin
		res = '0;
		if (is_enq) begin
			res.status = full ? ST_FULL : ST_OK;
		end else if (!any) begin
			res.status = ST_EMPTY;
		end else begin
			res.status = ST_OK;
			res.level  = LEVEL_W'(cur);
			res.slots  = SLOTS_W'(bud_new);
			res.use_rd = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PRIO_LEVELS; i++) begin
				head_q[i]  <= '0;
				count_q[i] <= '0;
			end
			serving_q <= '0;
			budget_q  <= '0;
		end else if (acc) begin
			if (is_enq) begin
				if (!full) begin
					count_q[idx] <= cnt_sel + 1'b1;
				end
			end else if (any) begin
				head_q[idx]  <= head_inc;
				count_q[idx] <= cnt_sel - 1'b1;
				budget_q     <= bud_new;
				serving_q    <= (bud_new == '0) ? cur_next : cur;
			end else begin
				budget_q <= '0;
			end
		end
	end

endmodule

### rtl/core/mlq_out.sv
module mlq_out import mlq_pkg::*; #(
	parameter int ID_BITS = DEF_ID_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               acc,
	input  res_t               res_in,
	input  logic [ID_BITS-1:0] rd_data,
	output logic               in_ready,
	output logic               m_valid,
	input  logic               m_ready,
	output logic [15:0]        m_data,
	output logic [1:0]         m_user
);

	logic                   valid_s1;
	res_t                   res_s1;
	logic                   out_valid_q;
	logic [15:0]            out_data_q;
	logic [1:0]             out_user_q;
	logic                   adv;
	logic [MAX_ID_BITS-1:0] rd_wide;
	logic [PID_W-1:0]       pid;

	assign adv      = valid_s1 && (!out_valid_q || m_ready);
	assign in_ready = !valid_s1 || adv;
	assign rd_wide  = MAX_ID_BITS'(rd_data);
	assign pid      = res_s1.use_rd ? rd_wide[PID_W-1:0] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (m_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			res_s1 <= res_in;
		end
		if (adv) begin
			out_data_q <= {1'b0, res_s1.slots, res_s1.level, pid};
			out_user_q <= res_s1.status;
		end
	end

	assign m_valid = out_valid_q;
	assign m_data  = out_data_q;
	assign m_user  = out_user_q;

endmodule

### rtl/core/multilevel_queue_slot_scheduler.sv
// Multilevel queue scheduler with per-level time slots. Each request either
// enqueues a process id on the FIFO of its priority level (0 is highest) or
// dispatches the next process; every request yields exactly one result. A
// request is accepted in every cycle as long as the result path drains: the
// queue bookkeeping and the level choice are decided in the acceptance cycle,
// the single-port id store is written or read at the accepting edge, and the
// result register is loaded from the stage behind the store once the result
// register is empty or being taken. A stalled result holds one more request
// in the stage between the store and the result register; after that,
// requests wait until the result is taken. The id store holds PRIO_LEVELS
// times QUEUE_DEPTH entries and needs no clearing after reset.
module multilevel_queue_slot_scheduler import mlq_pkg::*; #(
	parameter int PRIO_LEVELS = DEF_PRIO_LEVELS,
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
	parameter int ID_BITS     = DEF_ID_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // proc_id[7:0], level[10:8], zero[15:11]
	input  logic        s_axis_tuser,  // opcode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // picked_id[7:0], picked_level[10:8], slots_left[14:11], zero[15]
	output logic [1:0]  m_axis_tuser   // status
);

	localparam int ADDR_W = $clog2(PRIO_LEVELS * QUEUE_DEPTH);

	logic               acc;
	logic               ram_en;
	logic               ram_we;
	logic [ADDR_W-1:0]  ram_addr;
	logic [ID_BITS-1:0] ram_wdata;
	logic [ID_BITS-1:0] ram_rdata;
	res_t               res;
	op_t                opcode;

	assign acc    = s_axis_tvalid && s_axis_tready;
	assign opcode = op_t'(s_axis_tuser);

	mlq_ctrl #(
		.PRIO_LEVELS(PRIO_LEVELS),
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.ID_BITS(ID_BITS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.acc(acc),
		.opcode(opcode),
		.proc_id(s_axis_tdata[7:0]),
		.level(s_axis_tdata[10:8]),
		.ram_en(ram_en),
		.ram_we(ram_we),
		.ram_addr(ram_addr),
		.ram_wdata(ram_wdata),
		.res(res)
	);

	mlq_ram #(
		.WIDTH(ID_BITS),
		.DEPTH(PRIO_LEVELS * QUEUE_DEPTH)
	) u_store (
		.clk(clk),
		.en(ram_en),
		.we(ram_we),
		.addr(ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	mlq_out #(
		.ID_BITS(ID_BITS)
	) u_out (
		.clk(clk),
		.arst_n(arst_n),
		.acc(acc),
		.res_in(res),
		.rd_data(ram_rdata),
		.in_ready(s_axis_tready),
		.m_valid(m_axis_tvalid),
		.m_ready(m_axis_tready),
		.m_data(m_axis_tdata),
		.m_user(m_axis_tuser)
	);

endmodule

### rtl/core/mlq_checker.sv
module mlq_checker import mlq_pkg::*; #(
	parameter int PRIO_LEVELS = DEF_PRIO_LEVELS
) (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);

	// A stalled result keeps its contents.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result changed");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser == ST_OK || m_axis_tuser == ST_EMPTY ||
			m_axis_tuser == ST_FULL)
		else $error("undefined status code");

	// Failed requests carry no process, level or budget.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata == 16'd0)
		else $error("failed request carries data");

	// The budget loaded at a level never exceeds the level count minus the level.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && PRIO_LEVELS <= 8 |->
			32'(m_axis_tdata[14:11]) + 32'(m_axis_tdata[10:8]) <= PRIO_LEVELS - 1)
		else $error("slots left exceed the level budget");

endmodule

bind multilevel_queue_slot_scheduler mlq_checker #(
	.PRIO_LEVELS(PRIO_LEVELS)
) u_mlq_checker (
	.clk(clk),
	.arst_n(arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata),
	.m_axis_tuser(m_axis_tuser)
);

### verif/multilevel_queue_slot_scheduler_test.sv
`timescale 1ns / 100ps

module multilevel_queue_slot_scheduler_test;
	import mlq_pkg::*;

	localparam int NUM_LEVELS  = DEF_PRIO_LEVELS;
	localparam int FIFO_DEPTH  = DEF_QUEUE_DEPTH;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		status_t              status;
		logic [PID_W-1:0]     pid;
		logic [LEVEL_W-1:0]   lvl;
		logic [SLOTS_W-1:0]   slots;
	} sched_result_t;

	class sched_scoreboard;
		logic [PID_W-1:0] pid_store [NUM_LEVELS][FIFO_DEPTH];
		int               fifo_head [NUM_LEVELS];
		int               fifo_fill [NUM_LEVELS];
		int               serving_level;
		int               slot_budget;
		sched_result_t    expected_results [$];
		int               errors;

		function new();
			foreach (fifo_head[i]) begin
				fifo_head[i] = 0;
				fifo_fill[i] = 0;
			end
			serving_level = 0;
			slot_budget = 0;
			errors = 0;
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		// Updates the queue state for an accepted request and records its result.
		function void note_request(op_t op, logic [PID_W-1:0] pid, logic [LEVEL_W-1:0] lvl);
			sched_result_t r;
			int            lv;
			int            i;
			int            p;
			bit            found;
			r = '{ST_OK, '0, '0, '0};
			if (op == OP_ENQUEUE) begin
				lv = int'(lvl);
				if (lv >= NUM_LEVELS)
					lv = NUM_LEVELS - 1;
				if (fifo_fill[lv] >= FIFO_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					pid_store[lv][(fifo_head[lv] + fifo_fill[lv]) % FIFO_DEPTH] = pid;
					fifo_fill[lv]++;
				end
			end else begin
				if (serving_level >= NUM_LEVELS)
					serving_level = 0;
				// A higher priority level with work preempts the current one.
				for (i = 0; i < serving_level; i++) begin
					if (fifo_fill[i] != 0) begin
						serving_level = i;
						slot_budget = 0;
						break;
					end
				end
				if (slot_budget != 0 && fifo_fill[serving_level] == 0)
					slot_budget = 0;
				found = (slot_budget != 0);
				if (slot_budget == 0) begin
					for (i = 0; i < NUM_LEVELS; i++) begin
						p = (serving_level + i) % NUM_LEVELS;
						if (fifo_fill[p] != 0) begin
							serving_level = p;
							slot_budget = NUM_LEVELS - p;
							found = 1'b1;
							break;
						end
					end
				end
				if (!found) begin
					r.status = ST_EMPTY;
				end else begin
					r.pid = pid_store[serving_level][fifo_head[serving_level]];
					fifo_head[serving_level] = (fifo_head[serving_level] + 1) % FIFO_DEPTH;
					fifo_fill[serving_level]--;
					slot_budget--;
					r.lvl = LEVEL_W'(serving_level);
					r.slots = SLOTS_W'(slot_budget);
					if (slot_budget == 0)
						serving_level = (serving_level + 1) % NUM_LEVELS;
				end
			end
			expected_results.push_back(r);
		endfunction

		function void check_result(sched_result_t got);
			sched_result_t want;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result status=%0d id=%0d level=%0d slots=%0d",
					$time, got.status, got.pid, got.lvl, got.slots);
				errors++;
				return;
			end
			want = expected_results.pop_front();
			if (got.status !== want.status) begin
				$display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
				errors++;
			end
			if (got.pid !== want.pid) begin
				$display("%0t: picked_id expected %0d actual %0d", $time, want.pid, got.pid);
				errors++;
			end
			if (got.lvl !== want.lvl) begin
				$display("%0t: picked_level expected %0d actual %0d", $time, want.lvl, got.lvl);
				errors++;
			end
			if (got.slots !== want.slots) begin
				$display("%0t: slots_left expected %0d actual %0d", $time, want.slots, got.slots);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;

	sched_scoreboard sb;
	int              send_idle_pct = 0;
	int              recv_idle_pct = 0;
	int              cycle_count = 0;

	multilevel_queue_slot_scheduler #(
		.PRIO_LEVELS(NUM_LEVELS),
		.QUEUE_DEPTH(FIFO_DEPTH),
		.ID_BITS    (DEF_ID_BITS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Result side: values read right after the edge are the ones the block saw.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result('{status_t'(m_axis_tuser), m_axis_tdata[7:0],
				m_axis_tdata[10:8], m_axis_tdata[14:11]});
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Regression FAIL");
		$finish;
	end

	task automatic send_request(op_t op, logic [PID_W-1:0] pid, logic [LEVEL_W-1:0] lvl);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {5'b0, lvl, pid};
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_request(op, pid, lvl);
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Bursts pick filling, draining or mixed modes at random so that full
	// FIFOs, empty dispatches and budget rollover all come up.
	task automatic random_requests(int n_requests);
		int   sent;
		int   k;
		int   mode;
		int   burst;
		int   enq_pct;
		logic [LEVEL_W-1:0] focus;
		op_t  op;
		logic [LEVEL_W-1:0] lvl;
		sent = 0;
		while (sent < n_requests) begin
			mode = $urandom_range(3);
			burst = $urandom_range(4, 24);
			focus = LEVEL_W'($urandom_range(NUM_LEVELS - 1));
			case (mode)
				0: enq_pct = 80;
				1: enq_pct = 25;
				2: enq_pct = 50;
				default: enq_pct = 100;
			endcase
			for (k = 0; k < burst && sent < n_requests; k++) begin
				op = ($urandom_range(99) < enq_pct) ? OP_ENQUEUE : OP_DISPATCH;
				if (mode == 3 || $urandom_range(99) < 40)
					lvl = focus;
				else
					lvl = LEVEL_W'($urandom_range(NUM_LEVELS - 1));
				send_request(op, PID_W'($urandom_range(255)), lvl);
				sent++;
			end
		end
	endtask

	initial begin
		int i;
		sb = new();
		send_idle_pct = 31;
		recv_idle_pct = 62;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Nothing ready after reset, then the extreme ids and levels.
		send_request(OP_DISPATCH, 8'h00, 3'd0);
		send_request(OP_ENQUEUE, 8'h00, 3'd0);
		send_request(OP_ENQUEUE, 8'hFF, 3'd7);
		send_request(OP_DISPATCH, 8'hFF, 3'd7);
		send_request(OP_DISPATCH, 8'h00, 3'd0);
		send_request(OP_DISPATCH, 8'h5A, 3'd2);
		// A level emptied while budget remains must clear the budget and search again.
		send_request(OP_ENQUEUE, 8'hA5, 3'd5);
		send_request(OP_DISPATCH, 8'h00, 3'd0);
		send_request(OP_DISPATCH, 8'h00, 3'd0);
		// Fill one level and overflow it by one request.
		for (i = 0; i <= FIFO_DEPTH; i++)
			send_request(OP_ENQUEUE, 8'(i * 13 + 1), 3'd2);
		drain_results();

		random_requests(225);
		drain_results();

		send_idle_pct = 62;
		recv_idle_pct = 31;
		random_requests(225);
		drain_results();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_requests(225);
		drain_results();

		repeat (8) @(posedge clk);
		if (sb.pending() != 0) begin
			$display("%0t: %0d results never arrived", $time, sb.pending());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
